@@ design/slis_pkg.sv @@
// shared constants, codes and control types of the sorted leaf table block
// no dependencies; imported by every module of the block
`default_nettype none

package slis_pkg;

   // leaf geometry
   localparam int MAX_CELLS    = 15;
   localparam int LEFT_SPLIT   = 8;
   localparam int PAYLOAD_BITS = 32;
   localparam int KEEP_CELLS   = (LEFT_SPLIT < MAX_CELLS) ? LEFT_SPLIT : MAX_CELLS;
   // one spare slot holds the cell pushed out by an insert into a full leaf
   localparam int CELL_SLOTS   = MAX_CELLS + 1;
   localparam int CNT_W        = $clog2(CELL_SLOTS);
   localparam int IDX_W        = (CNT_W > 4) ? CNT_W : 4;

   // request opcodes
   localparam logic [1:0] OP_FIND   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_FIND   = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_SPLIT  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       search_step;
      logic       insert;
      logic       emit;
      logic [1:0] kind;
   } slis_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       search_done;
      logic       leaf_full;
      logic       split_last;
   } slis_status_type;

endpackage

`default_nettype wire

@@ design/sorted_leaf_table_insert_split_core.sv @@
// top level of the sorted leaf table: find, insert with split, read
// depends on slis_pkg, slis_ctrl and slis_datapath
`default_nettype none

// channel | direction | handshake            | item contents
// req     | in        | req_valid/req_stall  | opcode, search key, payload, cell index
// rsp     | out       | rsp_valid/rsp_stall  | kind, position, found, key, payload,
//         |           |                      | end of table, cell count, last
//
// sequence per item: accept, then for find and insert binary search steps
//   (at most 4 steps for 15 cells, one key compare per cycle through the
//   single store read port), then a finish step that loads the result once
//   the output register is free; a read goes from accept straight to finish
// an insert into a full leaf loads, in place of its insert result, one split result per split-off cell (8)
// reset clears the count and the control state; cell contents are undefined
// a stalled result holds in the output register; a new item is taken once the
//   previous one has loaded its last result, even while that result waits

module sorted_leaf_table_insert_split_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_search_key,
   input  logic [31:0] req_payload,
   input  logic [3:0]  req_cell_index,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_position,
   output logic        rsp_found,
   output logic [31:0] rsp_key_out,
   output logic [31:0] rsp_payload_out,
   output logic        rsp_end_of_table,
   output logic [3:0]  rsp_cell_count,
   output logic        rsp_last
);
   import slis_pkg::*;

   slis_cmd_type    cmd;
   slis_status_type status;

   // sequencer: accept, search steps, finish, split emission
   slis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // cell store with parallel shift, search window, result register
   slis_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_search_key   (req_search_key),
      .req_payload      (req_payload),
      .req_cell_index   (req_cell_index),
      .cmd              (cmd),
      .status           (status),
      .rsp_kind         (rsp_kind),
      .rsp_position     (rsp_position),
      .rsp_found        (rsp_found),
      .rsp_key_out      (rsp_key_out),
      .rsp_payload_out  (rsp_payload_out),
      .rsp_end_of_table (rsp_end_of_table),
      .rsp_cell_count   (rsp_cell_count),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

@@ design/slis_datapath.sv @@
// cell store, search registers, request and result registers of the leaf
// depends on slis_pkg; driven by slis_ctrl through slis_cmd_type
`default_nettype none

module slis_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 req_opcode,
   input  logic [31:0]                req_search_key,
   input  logic [31:0]                req_payload,
   input  logic [3:0]                 req_cell_index,
   input  slis_pkg::slis_cmd_type     cmd,
   output slis_pkg::slis_status_type  status,
   output logic [1:0]                 rsp_kind,
   output logic [3:0]                 rsp_position,
   output logic                       rsp_found,
   output logic [31:0]                rsp_key_out,
   output logic [31:0]                rsp_payload_out,
   output logic                       rsp_end_of_table,
   output logic [3:0]                 rsp_cell_count,
   output logic                       rsp_last
);
   import slis_pkg::*;

   // held request
   logic [1:0]              op_ff, op_in;
   logic [31:0]             key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [3:0]              idx_ff, idx_in;

   // leaf store, one spare slot on top
   logic [31:0]             key_store_ff [CELL_SLOTS];
   logic [31:0]             key_store_in [CELL_SLOTS];
   logic [PAYLOAD_BITS-1:0] pay_store_ff [CELL_SLOTS];
   logic [PAYLOAD_BITS-1:0] pay_store_in [CELL_SLOTS];
   logic [CNT_W-1:0]        count_ff, count_in;

   // search window and split cursor
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic                    hit_ff, hit_in;
   logic [CNT_W-1:0]        cursor_ff, cursor_in;

   // result register
   logic [1:0]              kind_ff, kind_in;
   logic [3:0]              pos_ff, pos_in;
   logic                    found_ff, found_in;
   logic [31:0]             kout_ff, kout_in;
   logic [31:0]             pout_ff, pout_in;
   logic                    eot_ff, eot_in;
   logic [3:0]              cnt_out_ff, cnt_out_in;
   logic                    last_ff, last_in;

   logic [CNT_W:0]          mid_sum;
   logic [CNT_W-1:0]        mid;
   logic [CNT_W-1:0]        rd_addr;
   logic [31:0]             rd_key;
   logic [PAYLOAD_BITS-1:0] rd_pay;
   logic                    read_ok;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_W:1];

   // single read port of the store
   always_comb begin
      if (cmd.search_step) begin
         rd_addr = mid;
      end else if (op_ff == OP_READ) begin
         rd_addr = CNT_W'(idx_ff);
      end else begin
         rd_addr = cursor_ff;
      end
   end
   assign rd_key = key_store_ff[rd_addr];
   assign rd_pay = pay_store_ff[rd_addr];

   assign read_ok = (IDX_W'(idx_ff) < IDX_W'(count_ff)) &&
                    (IDX_W'(idx_ff) < IDX_W'(MAX_CELLS));

   assign status.op          = op_ff;
   assign status.search_done = (lo_ff == hi_ff);
   assign status.leaf_full   = (count_ff == CNT_W'(MAX_CELLS));
   assign status.split_last  = (cursor_ff == CNT_W'(MAX_CELLS));

   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      pay_in    = pay_ff;
      idx_in    = idx_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      hit_in    = hit_ff;
      cursor_in = cursor_ff;
      count_in  = count_ff;
      for (int i = 0; i < CELL_SLOTS; i++) begin
         key_store_in[i] = key_store_ff[i];
         pay_store_in[i] = pay_store_ff[i];
      end

      if (cmd.load_req) begin
         op_in  = req_opcode;
         key_in = req_search_key;
         pay_in = req_payload;
         idx_in = req_cell_index;
         lo_in  = '0;
         hi_in  = count_ff;
         hit_in = 1'b0;
      end

      // one compare step; a hit collapses the window onto the match
      if (cmd.search_step) begin
         if (key_ff == rd_key) begin
            lo_in  = mid;
            hi_in  = mid;
            hit_in = 1'b1;
         end else if (key_ff < rd_key) begin
            hi_in = mid;
         end else begin
            lo_in = mid + CNT_W'(1);
         end
      end

      // parallel shift up from the insert position
      if (cmd.insert) begin
         if (lo_ff == '0) begin
            key_store_in[0] = key_ff;
            pay_store_in[0] = pay_ff;
         end
         for (int i = 1; i < CELL_SLOTS; i++) begin
            if (CNT_W'(i) == lo_ff) begin
               key_store_in[i] = key_ff;
               pay_store_in[i] = pay_ff;
            end else if (CNT_W'(i) > lo_ff) begin
               key_store_in[i] = key_store_ff[i-1];
               pay_store_in[i] = pay_store_ff[i-1];
            end
         end
         if (count_ff == CNT_W'(MAX_CELLS)) begin
            count_in  = CNT_W'(KEEP_CELLS);
            cursor_in = CNT_W'(KEEP_CELLS);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.emit && cmd.kind == KIND_SPLIT) begin
         cursor_in = cursor_ff + CNT_W'(1);
      end
   end

   // result fields
   always_comb begin
      kind_in    = cmd.kind;
      pos_in     = 4'(lo_ff);
      found_in   = 1'b0;
      kout_in    = '0;
      pout_in    = '0;
      eot_in     = 1'b0;
      cnt_out_in = 4'(count_in);
      last_in    = 1'b1;
      case (cmd.kind)
         KIND_FIND: begin
            found_in = hit_ff;
            eot_in   = (count_ff == '0);
         end
         KIND_READ: begin
            pos_in = idx_ff;
            eot_in = !read_ok;
            if (read_ok) begin
               kout_in = rd_key;
               pout_in = 32'(rd_pay);
            end
         end
         KIND_SPLIT: begin
            pos_in  = 4'(cursor_ff - CNT_W'(KEEP_CELLS));
            kout_in = rd_key;
            pout_in = 32'(rd_pay);
            last_in = status.split_last;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      pay_ff    <= pay_in;
      idx_ff    <= idx_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      hit_ff    <= hit_in;
      cursor_ff <= cursor_in;
      for (int i = 0; i < CELL_SLOTS; i++) begin
         key_store_ff[i] <= key_store_in[i];
         pay_store_ff[i] <= pay_store_in[i];
      end
      if (cmd.emit) begin
         kind_ff    <= kind_in;
         pos_ff     <= pos_in;
         found_ff   <= found_in;
         kout_ff    <= kout_in;
         pout_ff    <= pout_in;
         eot_ff     <= eot_in;
         cnt_out_ff <= cnt_out_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_kind         = kind_ff;
   assign rsp_position     = pos_ff;
   assign rsp_found        = found_ff;
   assign rsp_key_out      = kout_ff;
   assign rsp_payload_out  = pout_ff;
   assign rsp_end_of_table = eot_ff;
   assign rsp_cell_count   = cnt_out_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

@@ design/slis_ctrl.sv @@
// sequencing state machine and result valid register of the leaf
// depends on slis_pkg; steers slis_datapath through slis_cmd_type
`default_nettype none

module slis_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [1:0]                 req_opcode,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  slis_pkg::slis_status_type  status,
   output slis_pkg::slis_cmd_type     cmd
);
   import slis_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_SPLIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_opcode) inside
                  OP_FIND, OP_INSERT: state_in = ST_SEARCH;
                  OP_READ:            state_in = ST_FINISH;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (status.search_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.insert = (status.op == OP_INSERT);
               if (status.op == OP_INSERT && status.leaf_full) begin
                  state_in = ST_SPLIT;
               end else begin
                  cmd.emit = 1'b1;
                  case (status.op)
                     OP_FIND:   cmd.kind = KIND_FIND;
                     OP_INSERT: cmd.kind = KIND_INSERT;
                     default:   cmd.kind = KIND_READ;
                  endcase
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SPLIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_SPLIT;
               if (status.split_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ design/slis_checker.sv @@
// port-level checks of the sorted leaf table core, attached by bind
// depends on slis_pkg and sorted_leaf_table_insert_split_core
`default_nettype none

module slis_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic        rsp_found,
   input logic [3:0]  rsp_cell_count,
   input logic        rsp_last
);
   import slis_pkg::*;

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // only split-off cells can come in a run; every other kind ends its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SPLIT |-> rsp_last)
      else $error("single result without last");

   // after a split the leaf keeps exactly the lower half
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SPLIT |-> rsp_cell_count == 4'(KEEP_CELLS))
      else $error("split cell with wrong leaf count");

   // found is a find result only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_FIND |-> !rsp_found)
      else $error("found set outside a find result");

   // the leaf never reports more cells than it can hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_count <= 4'(MAX_CELLS))
      else $error("cell count beyond capacity");

endmodule

bind sorted_leaf_table_insert_split_core slis_checker u_slis_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_found      (rsp_found),
   .rsp_cell_count (rsp_cell_count),
   .rsp_last       (rsp_last)
);

`default_nettype wire

@@ verif/leaf_table_checker.sv @@
// checker for the sorted leaf table: watches both channels, keeps a shadow leaf,
// and compares every accepted result item with the oldest predicted one
// depends on slis_pkg for geometry, opcodes and result kinds
`timescale 1ns / 100ps

module leaf_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_search_key,
   input  logic [31:0] req_payload,
   input  logic [3:0]  req_cell_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [3:0]  rsp_position,
   input  logic        rsp_found,
   input  logic [31:0] rsp_key_out,
   input  logic [31:0] rsp_payload_out,
   input  logic        rsp_end_of_table,
   input  logic [3:0]  rsp_cell_count,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_results
);
   import slis_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  position;
      logic        found;
      logic [31:0] key;
      logic [31:0] pay;
      logic        eot;
      logic [3:0]  cells;
      logic        last;
   } leaf_result_type;

   logic [31:0]     shadow_key [MAX_CELLS];
   logic [31:0]     shadow_pay [MAX_CELLS];
   int              shadow_count;
   leaf_result_type leaf_results_q [$];
   leaf_result_type want;
   int              mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s got %h want %h", field, got, exp_val));
   endtask

   // lower-bound binary search over the held cells, stops early on an equal key
   function automatic int lower_bound(input logic [31:0] key, output logic hit);
      int lo;
      int hi;
      int mid;
      lo  = 0;
      hi  = shadow_count;
      hit = 1'b0;
      while (lo != hi) begin
         mid = (lo + hi) / 2;
         if (key == shadow_key[mid]) begin
            hit = 1'b1;
            return mid;
         end
         if (key < shadow_key[mid])
            hi = mid;
         else
            lo = mid + 1;
      end
      return lo;
   endfunction

   function automatic leaf_result_type leaf_result(input logic [1:0] kind, input int pos,
                                                   input logic found, input logic [31:0] key,
                                                   input logic [31:0] pay, input logic eot,
                                                   input logic last);
      leaf_result_type r;
      r.kind     = kind;
      r.position = pos[3:0];
      r.found    = found;
      r.key      = key;
      r.pay      = pay;
      r.eot      = eot;
      r.cells    = shadow_count[3:0];
      r.last     = last;
      return r;
   endfunction

   task automatic apply_leaf_op(input logic [1:0] op, input logic [31:0] key,
                                input logic [31:0] pay, input logic [3:0] idx);
      logic        hit;
      int          pos;
      logic [31:0] mk [CELL_SLOTS];
      logic [31:0] mp [CELL_SLOTS];
      case (op)
         OP_FIND: begin
            pos = lower_bound(key, hit);
            leaf_results_q.push_back(leaf_result(KIND_FIND, pos, hit, '0, '0,
                                                 shadow_count == 0, 1'b1));
         end
         OP_READ: begin
            if (int'(idx) < shadow_count)
               leaf_results_q.push_back(leaf_result(KIND_READ, idx, 1'b0, shadow_key[idx],
                                                    shadow_pay[idx], 1'b0, 1'b1));
            else
               leaf_results_q.push_back(leaf_result(KIND_READ, idx, 1'b0, '0, '0,
                                                    1'b1, 1'b1));
         end
         OP_INSERT: begin
            pos = lower_bound(key, hit);
            if (shadow_count < MAX_CELLS) begin
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_key[i] = shadow_key[i-1];
                  shadow_pay[i] = shadow_pay[i-1];
               end
               shadow_key[pos] = key;
               shadow_pay[pos] = pay;
               shadow_count++;
               leaf_results_q.push_back(leaf_result(KIND_INSERT, pos, 1'b0, '0, '0,
                                                    1'b0, 1'b1));
            end else begin
               // full leaf: merge, keep the low half, emit the rest
               for (int i = 0; i < CELL_SLOTS; i++) begin
                  if (i == pos) begin
                     mk[i] = key;
                     mp[i] = pay;
                  end else if (i > pos) begin
                     mk[i] = shadow_key[i-1];
                     mp[i] = shadow_pay[i-1];
                  end else begin
                     mk[i] = shadow_key[i];
                     mp[i] = shadow_pay[i];
                  end
               end
               for (int i = 0; i < KEEP_CELLS; i++) begin
                  shadow_key[i] = mk[i];
                  shadow_pay[i] = mp[i];
               end
               shadow_count = KEEP_CELLS;
               for (int i = KEEP_CELLS; i <= MAX_CELLS; i++)
                  leaf_results_q.push_back(leaf_result(KIND_SPLIT, i - KEEP_CELLS, 1'b0,
                                                       mk[i], mp[i], 1'b0,
                                                       i == MAX_CELLS));
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         leaf_results_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (leaf_results_q.size() == 0) begin
               report_mismatch("result item with nothing expected");
            end else begin
               want = leaf_results_q.pop_front();
               check_field("kind", 32'(rsp_kind), 32'(want.kind));
               check_field("position", 32'(rsp_position), 32'(want.position));
               check_field("found", 32'(rsp_found), 32'(want.found));
               check_field("key_out", rsp_key_out, want.key);
               check_field("payload_out", rsp_payload_out, want.pay);
               check_field("end_of_table", 32'(rsp_end_of_table), 32'(want.eot));
               check_field("cell_count", 32'(rsp_cell_count), 32'(want.cells));
               check_field("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (req_valid && !req_stall)
            apply_leaf_op(req_opcode, req_search_key, req_payload, req_cell_index);
      end
      pending_results <= leaf_results_q.size();
   end

endmodule

@@ verif/sorted_leaf_table_insert_split_core_test.sv @@
// top of the sorted leaf table testbench: clock, reset, request stimulus and
// result-side stalls; depends on slis_pkg, the core and leaf_table_checker
`timescale 1ns / 100ps

module sorted_leaf_table_insert_split_core_test;
   import slis_pkg::*;

   // opcode the block must ignore
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam int RANDOM_ITEMS  = 430;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;
   // watchdog limit, well above what a correct run needs
   localparam int CYCLE_LIMIT   = 250000;

   logic        clock;
   logic        reset;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode     = OP_FIND;
   logic [31:0] req_search_key = '0;
   logic [31:0] req_payload    = '0;
   logic [3:0]  req_cell_index = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_position;
   logic        rsp_found;
   logic [31:0] rsp_key_out;
   logic [31:0] rsp_payload_out;
   logic        rsp_end_of_table;
   logic [3:0]  rsp_cell_count;
   logic        rsp_last;

   int          fail_count;
   int          pending_results;
   int          cycles = 0;
   int          hold_left = 0;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;
   logic        steady = 1'b0;
   logic [31:0] key_pool [$];

   sorted_leaf_table_insert_split_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_search_key   (req_search_key),
      .req_payload      (req_payload),
      .req_cell_index   (req_cell_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_position     (rsp_position),
      .rsp_found        (rsp_found),
      .rsp_key_out      (rsp_key_out),
      .rsp_payload_out  (rsp_payload_out),
      .rsp_end_of_table (rsp_end_of_table),
      .rsp_cell_count   (rsp_cell_count),
      .rsp_last         (rsp_last)
   );

   leaf_table_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_search_key   (req_search_key),
      .req_payload      (req_payload),
      .req_cell_index   (req_cell_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_position     (rsp_position),
      .rsp_found        (rsp_found),
      .rsp_key_out      (rsp_key_out),
      .rsp_payload_out  (rsp_payload_out),
      .rsp_end_of_table (rsp_end_of_table),
      .rsp_cell_count   (rsp_cell_count),
      .rsp_last         (rsp_last),
      .fail_count       (fail_count),
      .pending_results  (pending_results)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: a hung block or a lost result ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sorted_leaf_table_insert_split_core regression: fail");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off when the sender asks for it,
   // and no stalls at all while the steady stretch runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 11);
      end
   end

   // raise valid with the item and wait for the accepting edge; the payload
   // stays put while stalled and valid is left high for the caller to decide
   task automatic offer_item(input logic [1:0] op, input logic [31:0] key,
                             input logic [31:0] pay, input logic [3:0] idx);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_search_key <= key;
      req_payload    <= pay;
      req_cell_index <= idx;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (op == OP_INSERT) begin
         key_pool.push_back(key);
         if (key_pool.size() > 32)
            void'(key_pool.pop_front());
      end
   endtask

   // sender idles after about one item in nine, never during the steady stretch
   task automatic maybe_gap();
      if (!steady && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   // drop valid and wait for every outstanding result item
   task automatic drain_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   // keys lean toward ones already inserted so finds hit and inserts duplicate;
   // small keys and the extremes crowd the ordering, the rest spread everywhere
   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30 && key_pool.size() > 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (r < 45)
         return 32'($urandom_range(0, 15));
      if (r < 52)
         return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      return $urandom;
   endfunction

   initial begin
      int          issued;
      int          r;
      logic [1:0]  op;
      reset = 1'b1;
      repeat (12)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty leaf behavior first
      offer_item(OP_FIND, 32'h1234_5678, '0, 4'd0);
      offer_item(OP_READ, '0, '0, 4'd0);
      offer_item(OP_READ, '0, '0, 4'd15);
      offer_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
      // extremes, then a duplicate that must land in front of its twin
      offer_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
      offer_item(OP_INSERT, 32'h0, 32'h0, 4'd0);
      offer_item(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 4'd0);
      offer_item(OP_INSERT, 32'h8000_0000, 32'h5A5A_5A5A, 4'd0);
      offer_item(OP_FIND, 32'h8000_0000, '0, 4'd0);
      offer_item(OP_FIND, 32'h0000_0007, '0, 4'd0);
      // fill to full, then one more insert forces the split
      for (int j = 1; j <= 12; j++) begin
         offer_item(OP_INSERT, 32'h0F00_0000 * j + j, ~(32'h0F00_0000 * j), 4'd0);
         maybe_gap();
      end
      offer_item(OP_READ, '0, '0, 4'd7);
      offer_item(OP_READ, '0, '0, 4'd8);
      offer_item(OP_READ, '0, '0, 4'd0);
      drain_pause();

      // random: insert-heavy so the leaf keeps filling and splitting
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         if (issued == 60)
            hold_go <= 1'b1;
         if (issued == 200)
            steady <= 1'b1;
         if (issued == 280)
            steady <= 1'b0;
         r = $urandom_range(0, 99);
         if (r < 45)
            op = OP_INSERT;
         else if (r < 70)
            op = OP_FIND;
         else if (r < 95)
            op = OP_READ;
         else
            op = OP_NONE;
         offer_item(op, pick_key(), $urandom, 4'($urandom_range(0, 15)));
         if (op != OP_NONE)
            issued++;
         if (issued == 300 && op != OP_NONE)
            drain_pause();
         else
            maybe_gap();
      end

      // wind down: nothing outstanding, then a quiet DRAIN_CYCLES stretch for strays
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (fail_count == 0)
         $display("sorted_leaf_table_insert_split_core regression: pass");
      else
         $display("sorted_leaf_table_insert_split_core regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
design/slis_pkg.sv
design/slis_datapath.sv
design/slis_ctrl.sv
design/sorted_leaf_table_insert_split_core.sv
design/slis_checker.sv
verif/leaf_table_checker.sv
verif/sorted_leaf_table_insert_split_core_test.sv
